[rtl/core/segx_pkg.sv]
package segx_pkg;

  localparam int COORD_W = 32;
  // differences of two coordinates
  localparam int DIF_W   = COORD_W + 1;
  // product of two differences
  localparam int PROD_W  = 2 * DIF_W;
  // difference of two products (d, e, f)
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  // numerator |d| * |a| ahead of the divide
  localparam int NUM_W   = MAG_W + COORD_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } pair_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } isect_t;

endpackage

[rtl/core/segment_intersection.sv]
// Channel   Valid        Stall        Word
// -------   -----------  -----------  ----------------------------------
// pair      pair_valid   pair_stall   segx_pkg::pair_t, two segments
// isect     isect_valid  isect_stall  segx_pkg::isect_t, hit and point
//
// One word enters per cycle while pair_stall is low; after five stages of
// differences, products, cross terms and numerator, a restoring divider
// produces one quotient bit per stage.
// Reset clears the valid bits of every stage, the output and the skid word.
// A stalled result parks the next one in a skid register; pair_stall comes
// from that register alone, so the whole pipeline holds only once it fills.
module segment_intersection (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  segx_pkg::pair_t  pair,
  output logic             isect_valid,
  input  logic             isect_stall,
  output segx_pkg::isect_t isect
);

  localparam int W       = segx_pkg::COORD_W;
  localparam int DIF_W   = segx_pkg::DIF_W;
  localparam int PROD_W  = segx_pkg::PROD_W;
  localparam int CROSS_W = segx_pkg::CROSS_W;
  localparam int MAG_W   = segx_pkg::MAG_W;
  localparam int NUM_W   = segx_pkg::NUM_W;

  typedef struct packed {
    logic                hit;
    logic                fzero;
    logic                xneg;
    logic                yneg;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
  } side_t;

  function automatic logic span_ok(input logic signed [CROSS_W-1:0] v,
                                   input logic signed [CROSS_W-1:0] f);
    logic f_pos;
    logic v_neg;
    logic v_pos;
    f_pos = !f[CROSS_W-1] && (f != '0);
    v_neg = v[CROSS_W-1];
    v_pos = !v[CROSS_W-1] && (v != '0);
    if (f_pos) begin
      span_ok = !v_neg && (v <= f);
    end else begin
      span_ok = !v_pos && (v >= f);
    end
  endfunction

  logic en;
  logic skid_valid;
  segx_pkg::isect_t skid;
  segx_pkg::isect_t fin;
  logic take;

  assign en         = !skid_valid;
  assign pair_stall = skid_valid;

  // ---------------- stage 1: differences ----------------
  logic                    s1_valid;
  segx_pkg::pair_t         s1_pair;
  logic signed [DIF_W-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pair <= pair;
      s1_ax   <= DIF_W'(pair.a_end_x) - DIF_W'(pair.a_start_x);
      s1_ay   <= DIF_W'(pair.a_end_y) - DIF_W'(pair.a_start_y);
      s1_bx   <= DIF_W'(pair.b_start_x) - DIF_W'(pair.b_end_x);
      s1_by   <= DIF_W'(pair.b_start_y) - DIF_W'(pair.b_end_y);
      s1_cx   <= DIF_W'(pair.a_start_x) - DIF_W'(pair.b_start_x);
      s1_cy   <= DIF_W'(pair.a_start_y) - DIF_W'(pair.b_start_y);
    end
  end

  // ---------------- stage 2: products, bounding boxes ----------------
  logic signed [W-1:0] lox, hix, loy, hiy;
  logic                bx_pos, by_pos, box_x, box_y;

  always_comb begin
    if (s1_ax[DIF_W-1]) begin
      lox = s1_pair.a_end_x;
      hix = s1_pair.a_start_x;
    end else begin
      lox = s1_pair.a_start_x;
      hix = s1_pair.a_end_x;
    end
    if (s1_ay[DIF_W-1]) begin
      loy = s1_pair.a_end_y;
      hiy = s1_pair.a_start_y;
    end else begin
      loy = s1_pair.a_start_y;
      hiy = s1_pair.a_end_y;
    end
    bx_pos = !s1_bx[DIF_W-1] && (s1_bx != '0);
    by_pos = !s1_by[DIF_W-1] && (s1_by != '0);
    if (bx_pos) begin
      box_x = !(hix < s1_pair.b_end_x || s1_pair.b_start_x < lox);
    end else begin
      box_x = !(hix < s1_pair.b_start_x || s1_pair.b_end_x < lox);
    end
    if (by_pos) begin
      box_y = !(hiy < s1_pair.b_end_y || s1_pair.b_start_y < loy);
    end else begin
      box_y = !(hiy < s1_pair.b_start_y || s1_pair.b_end_y < loy);
    end
  end

  logic                     s2_valid;
  logic                     s2_box_ok;
  segx_pkg::pair_t          s2_pair;
  logic signed [DIF_W-1:0]  s2_ax, s2_ay;
  logic signed [PROD_W-1:0] s2_by_cx, s2_bx_cy, s2_ay_bx, s2_ax_by, s2_ax_cy, s2_ay_cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_box_ok <= box_x && box_y;
      s2_pair   <= s1_pair;
      s2_ax     <= s1_ax;
      s2_ay     <= s1_ay;
      s2_by_cx  <= PROD_W'(s1_by) * PROD_W'(s1_cx);
      s2_bx_cy  <= PROD_W'(s1_bx) * PROD_W'(s1_cy);
      s2_ay_bx  <= PROD_W'(s1_ay) * PROD_W'(s1_bx);
      s2_ax_by  <= PROD_W'(s1_ax) * PROD_W'(s1_by);
      s2_ax_cy  <= PROD_W'(s1_ax) * PROD_W'(s1_cy);
      s2_ay_cx  <= PROD_W'(s1_ay) * PROD_W'(s1_cx);
    end
  end

  // ---------------- stage 3: cross terms d, e, f ----------------
  logic                      s3_valid;
  logic                      s3_box_ok;
  segx_pkg::pair_t           s3_pair;
  logic signed [DIF_W-1:0]   s3_ax, s3_ay;
  logic signed [CROSS_W-1:0] s3_d, s3_e, s3_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_box_ok <= s2_box_ok;
      s3_pair   <= s2_pair;
      s3_ax     <= s2_ax;
      s3_ay     <= s2_ay;
      s3_d      <= CROSS_W'(s2_by_cx) - CROSS_W'(s2_bx_cy);
      s3_e      <= CROSS_W'(s2_ax_cy) - CROSS_W'(s2_ay_cx);
      s3_f      <= CROSS_W'(s2_ay_bx) - CROSS_W'(s2_ax_by);
    end
  end

  // ---------------- stage 4: span test, magnitudes ----------------
  side_t               side4;
  logic [MAG_W-1:0]    dmag4, fmag4;
  logic [DIF_W-1:0]    axabs, ayabs;

  always_comb begin
    side4.hit   = s3_box_ok && span_ok(s3_d, s3_f) && span_ok(s3_e, s3_f);
    side4.fzero = (s3_f == '0);
    side4.xneg  = s3_ax[DIF_W-1] ^ s3_d[CROSS_W-1] ^ s3_f[CROSS_W-1];
    side4.yneg  = s3_ay[DIF_W-1] ^ s3_d[CROSS_W-1] ^ s3_f[CROSS_W-1];
    side4.x1    = s3_pair.a_start_x;
    side4.y1    = s3_pair.a_start_y;
    // collinear: take b_start when e is zero, else b_end
    if (s3_e == '0) begin
      side4.px = s3_pair.b_start_x;
      side4.py = s3_pair.b_start_y;
    end else begin
      side4.px = s3_pair.b_end_x;
      side4.py = s3_pair.b_end_y;
    end
    dmag4 = s3_d[CROSS_W-1] ? MAG_W'(-s3_d) : MAG_W'(s3_d);
    fmag4 = s3_f[CROSS_W-1] ? MAG_W'(-s3_f) : MAG_W'(s3_f);
    axabs = s3_ax[DIF_W-1] ? DIF_W'(-s3_ax) : DIF_W'(s3_ax);
    ayabs = s3_ay[DIF_W-1] ? DIF_W'(-s3_ay) : DIF_W'(s3_ay);
  end

  logic             s4_valid;
  side_t            s4_side;
  logic [MAG_W-1:0] s4_dmag, s4_fmag;
  logic [W-1:0]     s4_axmag, s4_aymag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side  <= side4;
      s4_dmag  <= dmag4;
      s4_fmag  <= fmag4;
      s4_axmag <= axabs[W-1:0];
      s4_aymag <= ayabs[W-1:0];
    end
  end

  // ---------------- stage 5: numerator partial products ----------------
  logic             s5_valid;
  side_t            s5_side;
  logic [MAG_W-1:0] s5_fmag;
  logic [2*W-1:0]   s5_xlo, s5_ylo;
  logic [MAG_W-1:0] s5_xhi, s5_yhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side <= s4_side;
      s5_fmag <= s4_fmag;
      s5_xlo  <= (2*W)'(s4_dmag[W-1:0]) * (2*W)'(s4_axmag);
      s5_ylo  <= (2*W)'(s4_dmag[W-1:0]) * (2*W)'(s4_aymag);
      s5_xhi  <= MAG_W'(s4_dmag[MAG_W-1:W]) * MAG_W'(s4_axmag);
      s5_yhi  <= MAG_W'(s4_dmag[MAG_W-1:W]) * MAG_W'(s4_aymag);
    end
  end

  // ---------------- divider: sum, then one quotient bit per stage ----------------
  logic [NUM_W-1:0] numx, numy;

  assign numx = NUM_W'(s5_xlo) + (NUM_W'(s5_xhi) << W);
  assign numy = NUM_W'(s5_ylo) + (NUM_W'(s5_yhi) << W);

  logic             dv_valid [W+1];
  side_t            dv_side  [W+1];
  logic [MAG_W-1:0] dv_fmag  [W+1];
  logic [MAG_W-1:0] dv_remx  [W+1];
  logic [MAG_W-1:0] dv_remy  [W+1];
  logic [W-1:0]     dv_nlox  [W+1];
  logic [W-1:0]     dv_nloy  [W+1];
  logic [W-1:0]     dv_qx    [W+1];
  logic [W-1:0]     dv_qy    [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= s5_valid;
    end
  end

  // the upper numerator bits start below |f| whenever the pair hits
  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s5_side;
      dv_fmag[0] <= s5_fmag;
      dv_remx[0] <= numx[NUM_W-1:W];
      dv_remy[0] <= numy[NUM_W-1:W];
      dv_nlox[0] <= numx[W-1:0];
      dv_nloy[0] <= numy[W-1:0];
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [MAG_W:0] tx, ty;
    logic           gex, gey;

    assign tx  = {dv_remx[k], dv_nlox[k][W-1]};
    assign ty  = {dv_remy[k], dv_nloy[k][W-1]};
    assign gex = (tx >= {1'b0, dv_fmag[k]});
    assign gey = (ty >= {1'b0, dv_fmag[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (en) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[k+1] <= dv_side[k];
        dv_fmag[k+1] <= dv_fmag[k];
        dv_remx[k+1] <= gex ? MAG_W'(tx - {1'b0, dv_fmag[k]}) : tx[MAG_W-1:0];
        dv_remy[k+1] <= gey ? MAG_W'(ty - {1'b0, dv_fmag[k]}) : ty[MAG_W-1:0];
        dv_nlox[k+1] <= dv_nlox[k] << 1;
        dv_nloy[k+1] <= dv_nloy[k] << 1;
        dv_qx[k+1]   <= {dv_qx[k][W-2:0], gex};
        dv_qy[k+1]   <= {dv_qy[k][W-2:0], gey};
      end
    end
  end

  // ---------------- result word ----------------
  always_comb begin
    fin.hit     = dv_side[W].hit;
    fin.cross_x = '0;
    fin.cross_y = '0;
    if (dv_side[W].hit) begin
      if (dv_side[W].fzero) begin
        fin.cross_x = dv_side[W].px;
        fin.cross_y = dv_side[W].py;
      end else begin
        fin.cross_x = dv_side[W].xneg ? (dv_side[W].x1 - $signed(dv_qx[W]))
                                      : (dv_side[W].x1 + $signed(dv_qx[W]));
        fin.cross_y = dv_side[W].yneg ? (dv_side[W].y1 - $signed(dv_qy[W]))
                                      : (dv_side[W].y1 + $signed(dv_qy[W]));
      end
    end
  end

  // ---------------- output register and skid word ----------------
  assign take = !isect_valid || !isect_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      isect_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (take) begin
      // drain the skid word first; the pipeline is held while it is full
      isect_valid <= skid_valid || dv_valid[W];
      skid_valid  <= 1'b0;
    end else if (!skid_valid && dv_valid[W]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      isect <= skid_valid ? skid : fin;
    end else if (!skid_valid) begin
      skid <= fin;
    end
  end

endmodule
